// File: design/scli_pkg.sv
// Shared types, codes and keyword tables for the command line interpreter.
`timescale 1ns / 1ps
`default_nettype none

package scli_pkg;

  // Default configuration of the line buffer and number reader
  localparam int DEF_LINE_CAPACITY = 40;
  localparam int DEF_MAX_DIGITS    = 3;

  // Number accumulator: three decimal digits at most
  localparam int VAL_W = 10;

  // Keyword count
  localparam int NUM_KW = 7;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Result status codes
  typedef enum logic [3:0] {
    ST_ON         = 4'd0,
    ST_OFF        = 4'd1,
    ST_AUTO       = 4'd2,
    ST_PWM_SET    = 4'd3,
    ST_INC        = 4'd4,
    ST_DEC        = 4'd5,
    ST_INC_REFUSE = 4'd6,
    ST_DEC_REFUSE = 4'd7,
    ST_PWM_NODIG  = 4'd8,
    ST_PWM_RANGE  = 4'd9,
    ST_HELP       = 4'd10,
    ST_UNKNOWN    = 4'd11
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FLOOR   = 2'd0,
    CFG_CEILING = 2'd1,
    CFG_STEP    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pwm_floor;
    logic [7:0] pwm_ceiling;
    logic [7:0] speed_step;
  } cfg_t;

  // Keywords; KW_NONE stands for an unrecognised word
  typedef enum logic [2:0] {
    KW_PWM  = 3'd0,
    KW_ON   = 3'd1,
    KW_OFF  = 3'd2,
    KW_AUTO = 3'd3,
    KW_INC  = 3'd4,
    KW_DEC  = 3'd5,
    KW_HELP = 3'd6,
    KW_NONE = 3'd7
  } kw_e;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SCAN,
    BK_EXEC
  } back_state_t;

  // Parse phase within a line
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_WORD,
    PH_GAP,
    PH_NUM
  } phase_t;

  // What the scanner does with the current character
  typedef enum logic [1:0] {
    ACT_ADV,
    ACT_STAY,
    ACT_DROP,
    ACT_EXEC
  } act_t;

  // Buffer release from back end to front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // Keyword length in characters
  function automatic logic [2:0] kw_len(kw_e k);
    logic [2:0] l;
    unique case (k)
      KW_PWM:  l = 3'd3;
      KW_ON:   l = 3'd2;
      KW_OFF:  l = 3'd3;
      KW_AUTO: l = 3'd4;
      KW_INC:  l = 3'd3;
      KW_DEC:  l = 3'd3;
      KW_HELP: l = 3'd4;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  // Keyword character at a position (first character at position 0)
  function automatic logic [7:0] kw_char(kw_e k, logic [1:0] pos);
    logic [31:0] s;
    logic [7:0]  c;
    unique case (k)
      KW_PWM:  s = "PWM ";
      KW_ON:   s = "ON  ";
      KW_OFF:  s = "OFF ";
      KW_AUTO: s = "AUTO";
      KW_INC:  s = "INC ";
      KW_DEC:  s = "DEC ";
      KW_HELP: s = "HELP";
      default: s = 32'h0;
    endcase
    unique case (pos)
      2'd0:    c = s[31:24];
      2'd1:    c = s[23:16];
      2'd2:    c = s[15:8];
      default: c = s[7:0];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/scli_store.sv
// Two-bank line store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module scli_store
  import scli_pkg::*;
#(
  parameter int AW = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/scli_queue.sv
// Two-entry queue of finished lines (buffer bank and length).
`timescale 1ns / 1ps
`default_nettype none

module scli_queue
  import scli_pkg::*;
#(
  parameter int LW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic          push_bank,
  input  wire logic [LW-1:0] push_len,
  input  wire logic          pop,
  output logic               empty,
  output logic               full,
  output logic               head_bank,
  output logic      [LW-1:0] head_len
);

  logic          bank_q [2];
  logic [LW-1:0] len_q  [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign empty     = (count == 2'd0);
  assign full      = (count == 2'd2);
  assign head_bank = bank_q[rd_ptr];
  assign head_len  = len_q[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      bank_q[wr_ptr] <= push_bank;
      len_q[wr_ptr]  <= push_len;
    end
  end

endmodule

`default_nettype wire

// File: design/scli_front.sv
// Front end: takes characters, edits the current line, hands finished lines on.
`timescale 1ns / 1ps
`default_nettype none

module scli_front
  import scli_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int LW            = $clog2(LINE_CAPACITY)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rx_valid,
  output logic               rx_stall,
  input  wire logic [7:0]    rx_char,
  // line store write port
  output logic               wr_en,
  output logic [LW:0]        wr_addr,
  output logic [7:0]         wr_data,
  // queue push side
  output logic               push,
  output logic               push_bank,
  output logic [LW-1:0]      push_len,
  input  wire logic          q_full,
  // bank handed back by the back end
  input  wire release_t      rel
);

  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CAPACITY - 1);

  logic [LW-1:0] len;
  logic          cur;
  logic [1:0]    busy;

  logic is_bs;
  logic is_eol;
  logic is_print;
  logic take;

  // classify the incoming character
  always_comb begin
    is_bs    = (rx_char == CH_BS) || (rx_char == CH_DEL);
    is_eol   = (rx_char == CH_LF) || (rx_char == CH_CR);
    is_print = (rx_char >= CH_SPACE) && (rx_char <= CH_TILDE);
  end

  // hold off when the bank is still being parsed or the queue is full
  assign rx_stall = (is_print && busy[cur]) || (is_eol && (len != '0) && q_full);
  assign take     = rx_valid && !rx_stall;

  assign wr_en     = take && is_print && (len < LEN_MAX);
  assign wr_addr   = {cur, len};
  assign wr_data   = rx_char;
  assign push      = take && is_eol && (len != '0);
  assign push_bank = cur;
  assign push_len  = len;

  // line length and bank selection
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      cur <= 1'b0;
    end else if (take) begin
      priority if (is_bs) begin
        if (len != '0) begin
          len <= len - LW'(1);
        end
      end else if (is_eol) begin
        len <= '0;
        if (len != '0) begin
          cur <= ~cur;
        end
      end else if (wr_en) begin
        len <= len + LW'(1);
      end
    end
  end

  // bank busy flags: set on hand-over, cleared on release
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 2'b00;
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (push && (cur == 1'(b))) begin
          busy[b] <= 1'b1;
        end else if (rel.valid && (rel.bank == 1'(b))) begin
          busy[b] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/scli_back.sv
// Back end: walks a stored line, decodes the keyword and runs the command.
`timescale 1ns / 1ps
`default_nettype none

module scli_back
  import scli_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int MAX_DIGITS    = DEF_MAX_DIGITS,
  parameter int LW            = $clog2(LINE_CAPACITY)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  // queue pop side
  input  wire logic          q_empty,
  input  wire logic          head_bank,
  input  wire logic [LW-1:0] head_len,
  output logic               pop,
  // line store read port
  output logic               rd_en,
  output logic [LW:0]        rd_addr,
  input  wire logic [7:0]    rd_data,
  output release_t           rel,
  // result channel
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic [3:0]         status,
  output logic               relay_on,
  output logic               manual_mode,
  output logic [7:0]         pwm_value,
  output logic               at_max,
  output logic               at_min
);

  localparam int DW = $clog2(MAX_DIGITS + 1);

  back_state_t   state, state_next;
  phase_t        phase;
  logic          bank;
  logic [LW-1:0] len;
  logic [LW-1:0] idx;
  logic [NUM_KW-1:0] cand;
  logic [2:0]    n;
  kw_e           kw;
  logic [VAL_W-1:0] val;
  logic [DW-1:0] digits;

  // command state
  logic       relay_state;
  logic       mode_manual;
  logic [7:0] pwm_setting;
  logic       max_flag;
  logic       min_flag;
  status_e    status_q;

  // scanner decode
  logic [7:0]        c;
  logic [7:0]        up;
  logic              have;
  logic              is_sp;
  logic              is_al;
  logic              is_dg;
  logic [NUM_KW-1:0] cand_upd;
  kw_e               kw_hit;
  act_t              act;
  phase_t            phase_next;
  logic [VAL_W-1:0]  val_next;

  // command execution
  logic       exec_fire;
  status_e    st_new;
  logic       relay_new;
  logic       mode_new;
  logic [7:0] pwm_new;
  logic       max_new;
  logic       min_new;
  logic [8:0] sum;
  logic [8:0] diff;

  // classify the fetched character and track keyword candidates
  always_comb begin
    c     = rd_data;
    up    = (c >= 8'h61) ? (c & 8'hDF) : c;
    have  = (idx < len);
    is_sp = have && (c == CH_SPACE);
    is_al = have && (((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)));
    is_dg = have && (c >= 8'h30) && (c <= 8'h39);
    kw_hit = KW_NONE;
    for (int k = 0; k < NUM_KW; k++) begin
      cand_upd[k] = cand[k] && (n < kw_len(kw_e'(3'(k))))
                    && (kw_char(kw_e'(3'(k)), n[1:0]) == up);
      if (cand[k] && (kw_len(kw_e'(3'(k))) == n)) begin
        kw_hit = kw_e'(3'(k));
      end
    end
    val_next = VAL_W'(13'({val, 3'b000}) + 13'({val, 1'b0}) + 13'(c[3:0]));
  end

  // scanner decision per phase
  always_comb begin
    act        = ACT_ADV;
    phase_next = phase;
    unique case (phase)
      PH_LEAD: begin
        priority if (is_sp) begin
          act = ACT_ADV;
        end else if (is_al) begin
          act        = ACT_STAY;
          phase_next = PH_WORD;
        end else begin
          act = ACT_DROP;
        end
      end
      PH_WORD: begin
        priority if (is_al) begin
          act = ACT_ADV;
        end else if (kw_hit == KW_PWM) begin
          act        = ACT_STAY;
          phase_next = PH_GAP;
        end else begin
          act = ACT_EXEC;
        end
      end
      PH_GAP: begin
        if (is_sp) begin
          act = ACT_ADV;
        end else begin
          act        = ACT_STAY;
          phase_next = PH_NUM;
        end
      end
      PH_NUM: begin
        if (is_dg && (digits < DW'(MAX_DIGITS))) begin
          act = ACT_ADV;
        end else begin
          act = ACT_EXEC;
        end
      end
      default: act = ACT_DROP;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!q_empty) state_next = BK_FETCH;
      BK_FETCH: state_next = BK_SCAN;
      BK_SCAN: begin
        unique case (act)
          ACT_ADV:  state_next = BK_FETCH;
          ACT_STAY: state_next = BK_SCAN;
          ACT_DROP: state_next = BK_IDLE;
          default:  state_next = BK_EXEC;
        endcase
      end
      BK_EXEC:  if (exec_fire) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop       = (state == BK_IDLE) && !q_empty;
    rd_en     = (state == BK_FETCH);
    exec_fire = (state == BK_EXEC) && (!res_valid || !res_stall);
    rel.valid = exec_fire || ((state == BK_SCAN) && (act == ACT_DROP));
    rel.bank  = bank;
  end

  assign rd_addr = {bank, idx};

  // run the decoded command
  always_comb begin
    relay_new = relay_state;
    mode_new  = mode_manual;
    pwm_new   = pwm_setting;
    max_new   = max_flag;
    min_new   = min_flag;
    sum       = {1'b0, pwm_setting} + {1'b0, cfg.speed_step};
    diff      = {1'b0, pwm_setting} - {1'b0, cfg.speed_step};
    st_new    = ST_UNKNOWN;
    unique case (kw)
      KW_PWM: begin
        priority if (digits == '0) begin
          st_new = ST_PWM_NODIG;
        end else if ((val < VAL_W'(cfg.pwm_floor)) || (val > VAL_W'(cfg.pwm_ceiling))) begin
          st_new = ST_PWM_RANGE;
        end else begin
          st_new   = ST_PWM_SET;
          mode_new = 1'b1;
          pwm_new  = val[7:0];
          max_new  = (val == VAL_W'(cfg.pwm_ceiling));
          min_new  = (val == VAL_W'(cfg.pwm_floor));
        end
      end
      KW_ON: begin
        st_new    = ST_ON;
        relay_new = 1'b1;
      end
      KW_OFF: begin
        st_new    = ST_OFF;
        relay_new = 1'b0;
      end
      KW_AUTO: begin
        st_new   = ST_AUTO;
        mode_new = 1'b0;
        max_new  = 1'b0;
        min_new  = 1'b0;
      end
      KW_INC: begin
        if (!mode_manual) begin
          st_new = ST_INC_REFUSE;
        end else begin
          st_new  = ST_INC;
          min_new = 1'b0;
          if (sum >= {1'b0, cfg.pwm_ceiling}) begin
            pwm_new = cfg.pwm_ceiling;
            max_new = 1'b1;
          end else begin
            pwm_new = sum[7:0];
            max_new = 1'b0;
          end
        end
      end
      KW_DEC: begin
        if (!mode_manual) begin
          st_new = ST_DEC_REFUSE;
        end else begin
          st_new  = ST_DEC;
          max_new = 1'b0;
          if (diff[8] || (diff[7:0] <= cfg.pwm_floor)) begin
            pwm_new = cfg.pwm_floor;
            min_new = 1'b1;
          end else begin
            pwm_new = diff[7:0];
            min_new = 1'b0;
          end
        end
      end
      KW_HELP: st_new = ST_HELP;
      default: st_new = ST_UNKNOWN;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // parse registers
  always_ff @(posedge clk) begin
    if (pop) begin
      bank   <= head_bank;
      len    <= head_len;
      idx    <= '0;
      phase  <= PH_LEAD;
      cand   <= '1;
      n      <= 3'd0;
      kw     <= KW_NONE;
      val    <= '0;
      digits <= '0;
    end else if (state == BK_SCAN) begin
      phase <= phase_next;
      if (act == ACT_ADV) begin
        idx <= idx + LW'(1);
      end
      unique case (phase)
        PH_WORD: begin
          if (is_al) begin
            cand <= cand_upd;
            n    <= (n == 3'd7) ? n : n + 3'd1;
          end else begin
            kw <= kw_hit;
          end
        end
        PH_NUM: begin
          if (act == ACT_ADV) begin
            val    <= val_next;
            digits <= digits + DW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // command state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= 1'b0;
      mode_manual <= 1'b0;
      pwm_setting <= 8'd0;
      max_flag    <= 1'b0;
      min_flag    <= 1'b0;
      res_valid   <= 1'b0;
      status_q    <= ST_ON;
    end else begin
      if (exec_fire) begin
        relay_state <= relay_new;
        mode_manual <= mode_new;
        pwm_setting <= pwm_new;
        max_flag    <= max_new;
        min_flag    <= min_new;
        status_q    <= st_new;
        res_valid   <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // state changes only together with a new result, so it doubles as payload
  assign status      = status_q;
  assign relay_on    = relay_state;
  assign manual_mode = mode_manual;
  assign pwm_value   = pwm_setting;
  assign at_max      = max_flag;
  assign at_min      = min_flag;

endmodule

`default_nettype wire

// File: design/serial_command_line_interpreter.sv
// Serial command line interpreter: top level with configuration registers.
//
// Usage:
//   rx channel   : one received byte per transaction on rx_char (rx_valid/rx_stall).
//                  Printable bytes build the line, 0x08/0x7F erase, CR or LF ends it.
//   res channel  : one transaction per executed command (res_valid/res_stall):
//                  status code plus relay, mode, PWM setting and limit flags.
//   cfg channel  : cfg_index selects floor (0), ceiling (1) or step (2); cfg_ready
//                  is always high. Write only while no line is being processed.
// Timing:
//   A byte is taken in the cycle it is offered unless rx_stall holds it. A line end
//   hands the line to the parser; the parser reads the line store through its
//   single registered read port, fetching and then scanning each character.
//   Two line banks let the next line be typed while the previous one is parsed;
//   rx_stall rises only when both banks are in use or the line queue is full.
// Reset (rst, synchronous): empty line, relay off, automatic mode, PWM 0, flags
//   clear, floor 0, ceiling 255, step 10. No result is pending after reset.
// Stall: a result held by res_stall keeps the parser waiting; its fields stay.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_interpreter
  import scli_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int MAX_DIGITS    = DEF_MAX_DIGITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // character input
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_char,
  // configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // results
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [3:0]      status,
  output logic            relay_on,
  output logic            manual_mode,
  output logic [7:0]      pwm_value,
  output logic            at_max,
  output logic            at_min
);

  localparam int LW = $clog2(LINE_CAPACITY);

  cfg_t          cfg;
  logic          wr_en;
  logic [LW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [LW:0]   rd_addr;
  logic [7:0]    rd_data;
  logic          push;
  logic          push_bank;
  logic [LW-1:0] push_len;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  logic          head_bank;
  logic [LW-1:0] head_len;
  release_t      rel;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_floor   <= 8'd0;
      cfg.pwm_ceiling <= 8'd255;
      cfg.speed_step  <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FLOOR:   cfg.pwm_floor   <= cfg_data;
        CFG_CEILING: cfg.pwm_ceiling <= cfg_data;
        CFG_STEP:    cfg.speed_step  <= cfg_data;
        default:     ;
      endcase
    end
  end

  scli_front #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .LW            (LW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_char   (rx_char),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_bank (push_bank),
    .push_len  (push_len),
    .q_full    (q_full),
    .rel       (rel)
  );

  scli_store #(
    .AW (LW + 1)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scli_queue #(
    .LW (LW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bank (push_bank),
    .push_len  (push_len),
    .pop       (pop),
    .empty     (q_empty),
    .full      (q_full),
    .head_bank (head_bank),
    .head_len  (head_len)
  );

  scli_back #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .MAX_DIGITS    (MAX_DIGITS),
    .LW            (LW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .head_bank   (head_bank),
    .head_len    (head_len),
    .pop         (pop),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .rel         (rel),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .relay_on    (relay_on),
    .manual_mode (manual_mode),
    .pwm_value   (pwm_value),
    .at_max      (at_max),
    .at_min      (at_min)
  );

endmodule

`default_nettype wire

// File: design/scli_checker.sv
// Port-level checks for the command line interpreter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module scli_checker
  import scli_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_valid,
  input wire logic       rx_stall,
  input wire logic [7:0] rx_char,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [1:0] cfg_index,
  input wire logic [7:0] cfg_data,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [3:0] status,
  input wire logic       relay_on,
  input wire logic       manual_mode,
  input wire logic [7:0] pwm_value,
  input wire logic       at_max,
  input wire logic       at_min
);

  // a held result keeps its transaction
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(pwm_value))
    else $error("result changed while stalled");

  // nothing pending straight after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

  // a successful INC implies manual mode and not at the floor flag
  a_inc_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_INC) |-> manual_mode && !at_min)
    else $error("INC result with wrong mode or flags");

  // AUTO leaves automatic mode with both limit flags clear
  a_auto_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_AUTO) |-> !manual_mode && !at_max && !at_min)
    else $error("AUTO result with wrong mode or flags");

  // refused steps only ever happen in automatic mode
  a_refuse_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((status == ST_INC_REFUSE) || (status == ST_DEC_REFUSE)) |-> !manual_mode)
    else $error("step refused in manual mode");

endmodule

bind serial_command_line_interpreter scli_checker u_scli_checker (.*);

`default_nettype wire
